// File: rtl/received_range_tracker_core_assert.svh
// Assertion macros used by rrt_row of the range tracker RTL.
// Expects clk and rst in the scope of each use.
`ifndef RECEIVED_RANGE_TRACKER_CORE_ASSERT_SVH
`define RECEIVED_RANGE_TRACKER_CORE_ASSERT_SVH

// Check that a condition holds at every clock edge out of reset.
`define RRT_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define RRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/rrt_pkg.sv
// Shared types and codes for the received range tracker.
// No dependencies.
package rrt_pkg;

  localparam int PN_W   = 62;
  localparam int TIME_W = 64;

  // Command codes
  localparam logic [1:0] CMD_RECORD = 2'd0;
  localparam logic [1:0] CMD_RANGE  = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  // Status codes
  localparam logic [1:0] STAT_NEW  = 2'd0;
  localparam logic [1:0] STAT_DUP  = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MERGE,
    ST_EMIT
  } state_t;

  // Command broadcast to every cell of a row
  typedef struct packed {
    cell_op_t         op;
    logic [PN_W-1:0]  lo;
    logic [PN_W-1:0]  hi;
  } cell_ctrl_t;

  // Per-cell flags and contents
  typedef struct packed {
    logic             valid;
    logic             abv;
    logic             mrg;
    logic             cov;
    logic [PN_W-1:0]  s;
    logic [PN_W-1:0]  e;
  } cell_stat_t;

  // Reduced view of one row
  typedef struct packed {
    logic             any_mrg;
    logic             any_cov;
    logic [PN_W-1:0]  first_s;
    logic [PN_W-1:0]  first_e;
    logic             top_valid;
    logic [PN_W-1:0]  top_e;
  } row_stat_t;

endpackage

// File: rtl/rrt_in_if.sv
// Request channel of the range tracker: valid/ready plus command payload.
// Depends on rrt_pkg.
interface rrt_in_if import rrt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [1:0]        context_req;
  logic [PN_W-1:0]   range_low;
  logic [PN_W-1:0]   range_high;
  logic [TIME_W-1:0] arrival_time;

  modport source (output valid, command, context_req, range_low, range_high,
                  arrival_time, input ready);
  modport sink   (input valid, command, context_req, range_low, range_high,
                  arrival_time, output ready);
endinterface

// File: rtl/rrt_out_if.sv
// Result channel of the range tracker: valid/ready plus result payload.
// Depends on rrt_pkg.
interface rrt_out_if import rrt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic              covered;
  logic [PN_W-1:0]   largest_received;
  logic [TIME_W-1:0] largest_time;
  logic [5:0]        ranges_used;

  modport source (output valid, status, covered, largest_received, largest_time,
                  ranges_used, input ready);
  modport sink   (input valid, status, covered, largest_received, largest_time,
                  ranges_used, output ready);
endinterface

// File: rtl/rrt_cell.sv
// One range cell: holds a start/end pair, compares it with the broadcast range
// and shifts to or from its neighbors. Depends on rrt_pkg.
module rrt_cell import rrt_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  cell_ctrl_t      ctrl,
  input  logic            prev_abv,
  input  logic            prev_valid,
  input  logic [PN_W-1:0] prev_s,
  input  logic [PN_W-1:0] prev_e,
  input  logic            next_valid,
  input  logic [PN_W-1:0] next_s,
  input  logic [PN_W-1:0] next_e,
  output cell_stat_t      stat
);

  logic            valid;
  logic [PN_W-1:0] s;
  logic [PN_W-1:0] e;
  logic            abv;
  logic            blw;

  // Classify against the broadcast range: above, below, touching
  always_comb begin
    abv = valid && ({1'b0, s} > ({1'b0, ctrl.hi} + 63'd1));
    blw = valid && (({1'b0, e} + 63'd1) < {1'b0, ctrl.lo});
    stat.valid = valid;
    stat.abv   = abv;
    stat.mrg   = valid && !abv && !blw;
    stat.cov   = valid && (s <= ctrl.lo) && (ctrl.hi <= e);
    stat.s     = s;
    stat.e     = e;
  end

  // Cells at and past the insertion point shift down; on remove they shift up
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      unique case (ctrl.op)
        OP_INSERT: begin
          if (!abv) begin
            if (prev_abv) begin
              valid <= 1'b1;
              s     <= ctrl.lo;
              e     <= ctrl.hi;
            end else begin
              valid <= prev_valid;
              s     <= prev_s;
              e     <= prev_e;
            end
          end
        end
        OP_REMOVE: begin
          if (!abv) begin
            valid <= next_valid;
            s     <= next_s;
            e     <= next_e;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: rtl/rrt_row.sv
// Range table of one context: a chain of cells, the range count and the
// reductions over the cell flags. Depends on rrt_pkg and rrt_cell.
`include "received_range_tracker_core_assert.svh"
module rrt_row import rrt_pkg::*; #(
  parameter int MAX_RANGES = 32,
  parameter int CNT_W      = $clog2(MAX_RANGES + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  cell_ctrl_t       ctrl,
  output row_stat_t        stat,
  output logic [CNT_W-1:0] count
);

  cell_stat_t            cs [MAX_RANGES];
  logic [MAX_RANGES-1:0] valid_vec;

  // Chain the cells; the top cell sees an "above" neighbor, the last an empty one
  for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
    if (i == 0) begin : g_top
      rrt_cell u_cell (
        .clk, .rst, .ctrl,
        .prev_abv   (1'b1),
        .prev_valid (1'b0),
        .prev_s     ('0),
        .prev_e     ('0),
        .next_valid (cs[i+1].valid),
        .next_s     (cs[i+1].s),
        .next_e     (cs[i+1].e),
        .stat       (cs[i])
      );
    end else if (i == MAX_RANGES - 1) begin : g_last
      rrt_cell u_cell (
        .clk, .rst, .ctrl,
        .prev_abv   (cs[i-1].abv),
        .prev_valid (cs[i-1].valid),
        .prev_s     (cs[i-1].s),
        .prev_e     (cs[i-1].e),
        .next_valid (1'b0),
        .next_s     ('0),
        .next_e     ('0),
        .stat       (cs[i])
      );
    end else begin : g_mid
      rrt_cell u_cell (
        .clk, .rst, .ctrl,
        .prev_abv   (cs[i-1].abv),
        .prev_valid (cs[i-1].valid),
        .prev_s     (cs[i-1].s),
        .prev_e     (cs[i-1].e),
        .next_valid (cs[i+1].valid),
        .next_s     (cs[i+1].s),
        .next_e     (cs[i+1].e),
        .stat       (cs[i])
      );
    end
    assign valid_vec[i] = cs[i].valid;
  end

  // Reduce flags; pick the first touching cell, right after the last cell above
  always_comb begin
    stat.any_mrg   = 1'b0;
    stat.any_cov   = 1'b0;
    stat.first_s   = '0;
    stat.first_e   = '0;
    stat.top_valid = cs[0].valid;
    stat.top_e     = cs[0].e;
    for (int i = 0; i < MAX_RANGES; i++) begin
      stat.any_mrg = stat.any_mrg | cs[i].mrg;
      stat.any_cov = stat.any_cov | cs[i].cov;
      if (cs[i].mrg && ((i == 0) || cs[(i == 0) ? 0 : i-1].abv)) begin
        stat.first_s = stat.first_s | cs[i].s;
        stat.first_e = stat.first_e | cs[i].e;
      end
    end
  end

  // Track the number of ranges held
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      unique case (ctrl.op)
        OP_INSERT: count <= count + CNT_W'(1);
        OP_REMOVE: count <= count - CNT_W'(1);
        default:   count <= count;
      endcase
    end
  end

  `RRT_ASSERT_ALWAYS(a_count_matches, $countones(valid_vec) == 32'(count), "count mismatch")
  `RRT_ASSERT_ALWAYS(a_cells_packed, ((valid_vec >> 1) & ~valid_vec) == '0, "hole in row")
  `RRT_ASSERT_NEXT(a_remove_dec, ctrl.op == OP_REMOVE, count == $past(count) - CNT_W'(1), "remove count")

endmodule

// File: rtl/received_range_tracker_core.sv
// Flow: a request is latched on transfer and checked in ST_CHECK; a record or range then
//   fuses each touching range in ST_MERGE and is inserted unless the table is full; a query,
//   duplicate, unused command or bad context goes to ST_EMIT; a busy rsp adds its stall.
// Throughput: one item at a time; the cell chain absorbs one touching range per cycle.
// Reset (rst, synchronous): all contexts empty, largest times zero, no result pending;
//   a request is taken while an earlier result waits. Uses rrt_pkg, the ifs, rrt_row.
module received_range_tracker_core import rrt_pkg::*; #(
  parameter int MAX_RANGES   = 32,
  parameter int NUM_CONTEXTS = 3
) (
  input  logic       clk,
  input  logic       rst,
  rrt_in_if.sink     req,
  rrt_out_if.source  rsp
);

  localparam int CNT_W = $clog2(MAX_RANGES + 1);

  state_t              state;
  state_t              state_next;
  logic [1:0]          cmd_q;
  logic [1:0]          ctx_q;
  logic [PN_W-1:0]     mlo;
  logic [PN_W-1:0]     mhi;
  logic [TIME_W-1:0]   time_q;
  logic                ts_upd;
  logic [1:0]          stat_q;
  logic                cov_q;
  logic [TIME_W-1:0]   arrival [NUM_CONTEXTS];

  row_stat_t           rs   [NUM_CONTEXTS];
  logic [CNT_W-1:0]    rcnt [NUM_CONTEXTS];
  row_stat_t           sel;
  logic [CNT_W-1:0]    sel_cnt;
  logic [TIME_W-1:0]   sel_time;
  logic                ctx_ok;
  logic                can_emit;
  logic                accept;
  cell_op_t            op;
  logic                do_time;
  logic                set_stat;
  logic [1:0]          stat_val;
  logic                cov_val;
  logic                load_out;

  assign ctx_ok   = 32'(ctx_q) < NUM_CONTEXTS;
  assign req.ready = (state == ST_IDLE);
  assign accept   = req.valid && req.ready;
  assign can_emit = !rsp.valid || rsp.ready;

  // Select the addressed context's row
  always_comb begin
    sel      = '0;
    sel_cnt  = '0;
    sel_time = '0;
    for (int r = 0; r < NUM_CONTEXTS; r++) begin
      if (32'(ctx_q) == r) begin
        sel      = rs[r];
        sel_cnt  = rcnt[r];
        sel_time = arrival[r];
      end
    end
  end

  // Range tables, one chain per context
  for (genvar r = 0; r < NUM_CONTEXTS; r++) begin : g_row
    cell_ctrl_t ctrl;
    always_comb begin
      ctrl.op = (32'(ctx_q) == r) ? op : OP_HOLD;
      ctrl.lo = mlo;
      ctrl.hi = mhi;
    end
    rrt_row #(.MAX_RANGES(MAX_RANGES), .CNT_W(CNT_W)) u_row (
      .clk, .rst, .ctrl,
      .stat  (rs[r]),
      .count (rcnt[r])
    );
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept) state_next = ST_CHECK;
      ST_CHECK: begin
        if (!ctx_ok || cmd_q == CMD_QUERY || sel.any_cov ||
            (cmd_q != CMD_RECORD && cmd_q != CMD_RANGE)) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_MERGE;
        end
      end
      ST_MERGE: if (!sel.any_mrg) state_next = ST_EMIT;
      ST_EMIT:  if (can_emit) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    op       = OP_HOLD;
    do_time  = 1'b0;
    set_stat = 1'b0;
    stat_val = STAT_DUP;
    cov_val  = 1'b0;
    load_out = 1'b0;
    unique case (state)
      ST_CHECK: begin
        set_stat = 1'b1;
        cov_val  = ctx_ok && (cmd_q == CMD_QUERY) && sel.any_cov;
      end
      ST_MERGE: begin
        if (sel.any_mrg) begin
          op = OP_REMOVE;
        end else if (sel_cnt == CNT_W'(MAX_RANGES)) begin
          set_stat = 1'b1;
          stat_val = STAT_FULL;
        end else begin
          op       = OP_INSERT;
          set_stat = 1'b1;
          stat_val = STAT_NEW;
          do_time  = (cmd_q == CMD_RECORD) && ts_upd;
        end
      end
      ST_EMIT:  load_out = can_emit;
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Largest-arrival timestamps
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NUM_CONTEXTS; r++) arrival[r] <= '0;
    end else if (do_time) begin
      for (int r = 0; r < NUM_CONTEXTS; r++) begin
        if (32'(ctx_q) == r) arrival[r] <= time_q;
      end
    end
  end

  // Latch the request, order the bounds, grow the running range on each fuse
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= req.command;
      ctx_q  <= req.context_req;
      time_q <= req.arrival_time;
      if (req.command == CMD_RECORD) begin
        mlo <= req.range_low;
        mhi <= req.range_low;
      end else if (req.range_high < req.range_low) begin
        mlo <= req.range_high;
        mhi <= req.range_low;
      end else begin
        mlo <= req.range_low;
        mhi <= req.range_high;
      end
    end else if (op == OP_REMOVE) begin
      if (sel.first_s < mlo) mlo <= sel.first_s;
      if (sel.first_e > mhi) mhi <= sel.first_e;
    end
    if (state == ST_CHECK) begin
      ts_upd <= !sel.top_valid || (mlo > sel.top_e);
    end
    if (set_stat) begin
      stat_q <= stat_val;
    end
    if (state == ST_CHECK) begin
      cov_q <= cov_val;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp.status           <= stat_q;
      rsp.covered          <= cov_q;
      rsp.largest_received <= (ctx_ok && sel.top_valid) ? sel.top_e : '0;
      rsp.largest_time     <= ctx_ok ? sel_time : '0;
      rsp.ranges_used      <= ctx_ok ? 6'(sel_cnt) : '0;
    end
  end

endmodule

// File: tb/tb_received_range_tracker_core_ifs.sv
// Interfaces for the range tracker testbench are the RTL ones; this file holds
// the shared testbench types. Depends on rrt_pkg.
`timescale 1ns / 1ps
package tb_rrt_pkg;
  import rrt_pkg::*;

  typedef struct {
    logic [1:0]        command;
    logic [1:0]        context_req;
    logic [PN_W-1:0]   range_low;
    logic [PN_W-1:0]   range_high;
    logic [TIME_W-1:0] arrival_time;
  } request_t;

  typedef struct {
    logic [1:0]        status;
    logic              covered;
    logic [PN_W-1:0]   largest_received;
    logic [TIME_W-1:0] largest_time;
    logic [5:0]        ranges_used;
  } result_t;
endpackage

// File: tb/tb_received_range_tracker_core.sv
// Testbench for received_range_tracker_core: directed table, then random
// record/range/query traffic checked against a behavioral range table.
// Depends on rrt_pkg, tb_rrt_pkg, rrt_in_if, rrt_out_if and the RTL.
`timescale 1ns / 1ps
module tb_received_range_tracker_core;
  import rrt_pkg::*;
  import tb_rrt_pkg::*;

  localparam int MAX_R   = 32;
  localparam int NUM_CTX = 3;
  localparam int N_RAND  = 1400;
  localparam int WD_LIMIT = 20000;
  localparam logic [PN_W-1:0] PN_MAX = {PN_W{1'b1}};
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] CTX_BAD = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  rrt_in_if  req ();
  rrt_out_if rsp ();

  received_range_tracker_core #(.MAX_RANGES(MAX_R), .NUM_CONTEXTS(NUM_CTX)) DUT (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp)
  );

  // Behavioral range tables, highest range first
  logic [PN_W-1:0]   tbl_s [NUM_CTX][$];
  logic [PN_W-1:0]   tbl_e [NUM_CTX][$];
  logic [TIME_W-1:0] top_time [NUM_CTX] = '{default: '0};

  result_t pending_results[$];
  int errors = 0;
  int n_sent = 0, n_recv = 0, n_full = 0, n_cov = 0;
  bit quiet_end = 0;
  bit long_hold = 0;
  int idle_cnt = 0;

  function automatic bit range_held(int c, logic [PN_W-1:0] lo, logic [PN_W-1:0] hi);
    for (int i = 0; i < tbl_s[c].size(); i++)
      if (tbl_s[c][i] <= lo && hi <= tbl_e[c][i]) return 1;
    return 0;
  endfunction

  // Fuse [lo,hi] into the table of context c; returns status code
  function automatic logic [1:0] fuse_range(int c, logic [PN_W-1:0] lo,
                                            logic [PN_W-1:0] hi);
    logic [PN_W-1:0] ns[$], ne[$];
    logic [PN_W:0] lo_x, hi_x, s_x, e_x;
    logic [PN_W-1:0] mlo, mhi;
    bit placed;
    placed = 0;
    mlo = lo;
    mhi = hi;
    if (range_held(c, lo, hi)) return STAT_DUP;
    lo_x = {1'b0, lo};
    hi_x = {1'b0, hi};
    for (int i = 0; i < tbl_s[c].size(); i++) begin
      s_x = {1'b0, tbl_s[c][i]};
      e_x = {1'b0, tbl_e[c][i]};
      if (s_x > hi_x + 1) begin
        ns.push_back(tbl_s[c][i]); ne.push_back(tbl_e[c][i]);
      end else if (e_x + 1 < lo_x) begin
        if (!placed) begin
          ns.push_back(mlo); ne.push_back(mhi); placed = 1;
        end
        ns.push_back(tbl_s[c][i]); ne.push_back(tbl_e[c][i]);
      end else begin
        if (tbl_s[c][i] < mlo) mlo = tbl_s[c][i];
        if (tbl_e[c][i] > mhi) mhi = tbl_e[c][i];
      end
    end
    if (!placed) begin
      ns.push_back(mlo); ne.push_back(mhi);
    end
    if (ns.size() > MAX_R) return STAT_FULL;
    tbl_s[c] = ns;
    tbl_e[c] = ne;
    return STAT_NEW;
  endfunction

  function automatic result_t track_request(request_t r);
    result_t res;
    logic [PN_W-1:0] lo, hi, tmp;
    int c;
    bit was_empty, is_above;
    res = '{STAT_DUP, 1'b0, '0, '0, '0};
    if (r.context_req >= NUM_CTX) return res;
    c = r.context_req;
    lo = r.range_low;
    hi = r.range_high;
    if (r.command != CMD_RECORD && hi < lo) begin
      tmp = lo; lo = hi; hi = tmp;
    end
    case (r.command)
      CMD_RECORD: begin
        was_empty = tbl_s[c].size() == 0;
        is_above = !was_empty && lo > tbl_e[c][0];
        res.status = fuse_range(c, lo, lo);
        if (res.status == STAT_NEW && (was_empty || is_above))
          top_time[c] = r.arrival_time;
      end
      CMD_RANGE: res.status = fuse_range(c, lo, hi);
      CMD_QUERY: res.covered = (tbl_s[c].size() != 0) && range_held(c, lo, hi);
      default: ;
    endcase
    res.largest_received = tbl_s[c].size() ? tbl_e[c][0] : '0;
    res.largest_time = top_time[c];
    res.ranges_used = 6'(tbl_s[c].size());
    if (res.status == STAT_FULL) n_full++;
    if (res.covered) n_cov++;
    return res;
  endfunction

  // Directed table; has_exp marks rows whose result is typed in
  typedef struct {
    request_t r;
    bit       has_exp;
    result_t  x;
  } dir_row_t;
  dir_row_t dir_rows[$];

  function automatic request_t mk(logic [1:0] cmd, logic [1:0] ctx,
                                  logic [PN_W-1:0] lo, logic [PN_W-1:0] hi,
                                  logic [TIME_W-1:0] t);
    request_t r;
    r.command = cmd; r.context_req = ctx; r.range_low = lo;
    r.range_high = hi; r.arrival_time = t;
    return r;
  endfunction

  task automatic add_row(request_t r);
    dir_rows.push_back('{r, 1'b0, '{STAT_NEW, 1'b0, '0, '0, '0}});
  endtask

  task automatic add_row_exp(request_t r, result_t x);
    dir_rows.push_back('{r, 1'b1, x});
  endtask

  task automatic build_table();
    // empty context, query: nothing covered
    add_row_exp(mk(CMD_QUERY, 2'd0, 62'd0, 62'd0, '0), '{STAT_DUP, 1'b0, '0, '0, 6'd0});
    // context out of range
    add_row_exp(mk(CMD_RECORD, CTX_BAD, 62'd5, 62'd5, 64'hFFFF),
                '{STAT_DUP, 1'b0, '0, '0, 6'd0});
    // first record in an empty context latches the time
    add_row_exp(mk(CMD_RECORD, 2'd0, PN_MAX, '0, {TIME_W{1'b1}}),
                '{STAT_NEW, 1'b0, PN_MAX, {TIME_W{1'b1}}, 6'd1});
    add_row_exp(mk(CMD_RECORD, 2'd0, PN_MAX, '0, 64'd1),
                '{STAT_DUP, 1'b0, PN_MAX, {TIME_W{1'b1}}, 6'd1});
    add_row_exp(mk(CMD_RECORD, 2'd1, 62'd0, PN_MAX, 64'd7),
                '{STAT_NEW, 1'b0, 62'd0, 64'd7, 6'd1});
    add_row(mk(CMD_RECORD, 2'd1, 62'd2, 62'd0, 64'd9));
    add_row(mk(CMD_RECORD, 2'd1, 62'd1, 62'd0, 64'd11));
    // reversed range bounds
    add_row(mk(CMD_RANGE, 2'd2, 62'd100, 62'd10, 64'd3));
    add_row(mk(CMD_QUERY, 2'd2, 62'd90, 62'd20, '0));
    add_row(mk(CMD_QUERY, 2'd2, 62'd9, 62'd20, '0));
    add_row(mk(CMD_RANGE, 2'd2, 62'd102, 62'd200, '0));
    add_row(mk(CMD_RANGE, 2'd2, 62'd101, 62'd101, '0));
    add_row(mk(CMD_RANGE, 2'd2, 62'd0, PN_MAX, '0));
    add_row(mk(CMD_QUERY, 2'd2, PN_MAX, 62'd0, '0));
    add_row(mk(CMD_QUERY, 2'd1, 62'd0, PN_MAX, '0));
    add_row(mk(CMD_UNUSED, 2'd0, 62'd3, 62'd3, 64'd5));
    add_row(mk(CMD_RANGE, 2'd0, 62'd0, 62'd0, 64'd5));
    add_row(mk(CMD_RECORD, 2'd0, 62'h2AAA_AAAA_AAAA_AAAA, '0, 64'h5555));
    add_row(mk(CMD_RANGE, CTX_BAD, PN_MAX, 62'd0, '1));
    add_row(mk(CMD_QUERY, CTX_BAD, 62'd0, 62'd0, '0));
  endtask

  // Context 0 is filled with isolated even numbers to push it to full
  function automatic request_t rand_request(int k);
    request_t r;
    int sel;
    logic [PN_W-1:0] base;
    sel = $urandom_range(0, 99);
    r.context_req = ($urandom_range(0, 19) == 0) ? CTX_BAD : 2'($urandom_range(0, 2));
    r.command = ($urandom_range(0, 49) == 0) ? CMD_UNUSED : 2'($urandom_range(0, 2));
    r.arrival_time = {$urandom, $urandom};
    base = (r.context_req == 2'd2) ? 62'd1000 : 62'd0;
    if (sel < 75) begin
      // small window so ranges touch, fuse and repeat
      r.range_low = base + $urandom_range(0, (r.context_req == 2'd0) ? 140 : 60);
      r.range_high = r.range_low + $urandom_range(0, 3) - ($urandom_range(0, 9) == 0 ? 2 : 0);
      if (r.context_req == 2'd0 && r.command != CMD_QUERY) begin
        r.range_low = {r.range_low[PN_W-1:1], 1'b0};
        r.range_high = r.range_low;
      end
    end else if (sel < 85) begin
      r.range_low = PN_MAX - $urandom_range(0, 8);
      r.range_high = PN_MAX - $urandom_range(0, 8);
    end else begin
      r.range_low = PN_W'({$urandom, $urandom});
      r.range_high = PN_W'({$urandom, $urandom});
    end
    return r;
  endfunction

  // Sender: drive one request until it transfers
  task automatic send_request(request_t r);
    int gap;
    if (!quiet_end && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.command <= r.command;
    req.context_req <= r.context_req;
    req.range_low <= r.range_low;
    req.range_high <= r.range_high;
    req.arrival_time <= r.arrival_time;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    n_sent++;
  endtask

  // Predict at the transfer edge, from the sampled payload
  always @(posedge clk) begin
    request_t r;
    if (!rst && req.valid && req.ready) begin
      r = mk(req.command, req.context_req, req.range_low, req.range_high, req.arrival_time);
      pending_results.push_back(track_request(r));
    end
  end

  // Override predictions with typed-in rows when they apply
  result_t typed_q[$];
  bit      typed_flag_q[$];

  // Check each result transfer against the oldest expectation
  always @(posedge clk) begin
    result_t x;
    result_t tx;
    bit use_typed;
    if (!rst && rsp.valid && rsp.ready) begin
      n_recv++;
      use_typed = 0;
      if (typed_flag_q.size()) begin
        use_typed = typed_flag_q.pop_front();
        tx = typed_q.pop_front();
      end
      if (pending_results.size() == 0) begin
        $error("result with no request waiting");
        errors++;
      end else begin
        x = pending_results.pop_front();
        if (use_typed) x = tx;
        if (rsp.status !== x.status) begin
          $error("status exp %0d got %0d", x.status, rsp.status); errors++;
        end
        if (rsp.covered !== x.covered) begin
          $error("covered exp %0d got %0d", x.covered, rsp.covered); errors++;
        end
        if (rsp.largest_received !== x.largest_received) begin
          $error("largest_received exp %0h got %0h", x.largest_received,
                 rsp.largest_received); errors++;
        end
        if (rsp.largest_time !== x.largest_time) begin
          $error("largest_time exp %0h got %0h", x.largest_time, rsp.largest_time);
          errors++;
        end
        if (rsp.ranges_used !== x.ranges_used) begin
          $error("ranges_used exp %0d got %0d", x.ranges_used, rsp.ranges_used);
          errors++;
        end
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off, none near the end
  initial begin
    int burst;
    rsp.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (long_hold) begin
        rsp.ready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 0;
      end else if (!quiet_end && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 16);
        rsp.ready <= 1'b0;
        repeat (burst) @(posedge clk);
      end else begin
        rsp.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WD_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    req.valid <= 1'b0;
    req.command <= CMD_RECORD;
    req.context_req <= '0;
    req.range_low <= '0;
    req.range_high <= '0;
    req.arrival_time <= '0;
    build_table();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed rows
    foreach (dir_rows[i]) begin
      typed_flag_q.push_back(dir_rows[i].has_exp);
      typed_q.push_back(dir_rows[i].x);
      send_request(dir_rows[i].r);
    end
    // Random traffic
    for (int k = 0; k < N_RAND; k++) begin
      if (k == 400) long_hold = 1;
      if (k == N_RAND - 150) quiet_end = 1;
      send_request(rand_request(k));
    end
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Ran %0d requests, %0d results; %0d full tables, %0d covered queries.",
             n_sent, n_recv, n_full, n_cov);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/rrt_pkg.sv
rtl/rrt_in_if.sv
rtl/rrt_out_if.sv
rtl/rrt_cell.sv
rtl/rrt_row.sv
rtl/received_range_tracker_core.sv
tb/tb_received_range_tracker_core_ifs.sv
tb/tb_received_range_tracker_core.sv
